// File: sv/spfd_pkg.sv
// Package for the schema packet field decoder.
// Holds codec, status and phase codes, the result type and controller commands.
// No dependencies.
`default_nettype none
package spfd_pkg;

  localparam logic [7:0] MARK_COMPACT = 8'hFD;
  localparam logic [7:0] MARK_BATCH   = 8'hFC;
  localparam logic [15:0] DICT_LEN    = 16'hFFFF;

  localparam logic [1:0] REG_MSG_ID = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_CODECS = 2'd2;

  localparam logic [3:0] C_U8  = 4'd0;
  localparam logic [3:0] C_U16 = 4'd1;
  localparam logic [3:0] C_U32 = 4'd2;
  localparam logic [3:0] C_I8  = 4'd3;
  localparam logic [3:0] C_I16 = 4'd4;
  localparam logic [3:0] C_I32 = 4'd5;
  localparam logic [3:0] C_F32 = 4'd6;
  localparam logic [3:0] C_F64 = 4'd7;
  localparam logic [3:0] C_STR = 4'd8;
  localparam logic [3:0] C_BYT = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SMALL    = 3'd1;
  localparam logic [2:0] ST_BATCH    = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

  typedef enum logic [3:0] {
    PH_B0, PH_B1, PH_MODE, PH_BSIZE, PH_BMAP, PH_FIELD, PH_DICTID, PH_PAYLOAD,
    PH_DONE, PH_ERR
  } phase_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  field_index;
    logic [3:0]  field_codec;
    logic [63:0] field_value;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic        is_dictionary_ref;
    logic [15:0] dictionary_id;
    logic [2:0]  status;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic byte_go;
    logic eop;
    logic adv_go;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic adv_pending;
    logic emit;
  } dp_stat_t;

  function automatic logic [3:0] fixed_size(input logic [3:0] c);
    logic [3:0] s;
    begin
      case (c)
        C_U8, C_I8: s = 4'd1;
        C_U16, C_I16: s = 4'd2;
        C_U32, C_I32, C_F32: s = 4'd4;
        default: s = 4'd8;
      endcase
      return s;
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/spfd_if.sv
// Valid/ready channel interfaces for the decoder.
// Depends on spfd_pkg.
`default_nettype none
interface spfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_packet;
  modport source(output valid, in_byte, end_of_packet, input ready);
  modport sink(input valid, in_byte, end_of_packet, output ready);
endinterface

interface spfd_out_if import spfd_pkg::*;;
  logic    valid;
  logic    ready;
  result_t res;
  modport source(output valid, res, input ready);
  modport sink(input valid, res, output ready);
endinterface

interface spfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/spfd_ctrl.sv
// Controller: accepts items and sequences the datapath, one result per cycle while the output is free.
// Depends on spfd_pkg.
`default_nettype none
module spfd_ctrl import spfd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_eop,
  input  wire logic     out_free,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ADV  = 3'b010,
    S_EOP  = 3'b100
  } cst_t;

  cst_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.byte_go = 1'b1;
          cmd.eop = in_eop;
          if (stat.adv_pending) state_nxt = S_ADV;
          else if (in_eop) state_nxt = S_EOP;
        end
      end
      S_ADV: begin
        if (out_free) begin
          cmd.adv_go = 1'b1;
          if (!stat.adv_pending) state_nxt = stat.busy ? S_EOP : S_IDLE;
        end
      end
      S_EOP: begin
        if (out_free) begin
          cmd.adv_go = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// File: sv/spfd_dp.sv
// Datapath: packet state, field assembly and the advance walk over zeroed fields.
// Depends on spfd_pkg.
`default_nettype none
module spfd_dp import spfd_pkg::*; #(
  parameter int FIELD_SLOTS = 16,
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_byte,
  input  dp_cmd_t          cmd,
  input  wire logic [15:0] msg_id,
  input  wire logic [4:0]  fcount,
  input  wire logic [63:0] codecs,
  output dp_stat_t         stat,
  output result_t          res
);
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]  first_r, first_nxt;
  phase_t      ph_r, ph_nxt;
  logic        cmp_r, cmp_nxt;
  logic [4:0]  cur_r, cur_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [63:0] val_r, val_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] bmap_r, bmap_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        adv_r, adv_nxt;
  logic        eop_r, eop_nxt;

  logic [4:0]  live;
  logic [4:0]  need;
  logic [3:0]  c;
  logic [OFFSET_BITS-1:0] npos;
  logic [15:0] npos16;
  logic [63:0] v;
  logic [2:0]  st;
  logic        start_adv;
  logic        go;
  phase_t      fph;

  always_comb begin
    live = (fcount > 5'(FIELD_SLOTS)) ? 5'(FIELD_SLOTS) : fcount;
    need = (live + 5'd7) >> 3;
    c = codecs[{cur_r[3:0], 2'b00} +: 4];
    npos = (pos_r < POS_MAX) ? pos_r + 1'b1 : POS_MAX;
    npos16 = 16'(npos);
    fph = (ph_r == PH_MODE) ? PH_FIELD : ph_r;
  end

  always_comb begin
    pos_nxt = pos_r; first_nxt = first_r; ph_nxt = ph_r; cmp_nxt = cmp_r;
    cur_nxt = cur_r; seen_nxt = seen_r; val_nxt = val_r; len_nxt = len_r;
    bmap_nxt = bmap_r; err_nxt = err_r; adv_nxt = adv_r; eop_nxt = eop_r;
    res = '0;
    stat.emit = 1'b0;
    start_adv = 1'b0;
    go = 1'b0;
    v = '0;
    st = ST_BAD;
    if (cmd.byte_go) begin
      pos_nxt = npos;
      eop_nxt = cmd.eop;
      unique case (ph_r)
        PH_B0: begin first_nxt = in_byte; ph_nxt = PH_B1; end
        PH_B1: begin
          if (first_r == MARK_BATCH) begin err_nxt = ST_BATCH; ph_nxt = PH_ERR; end
          else if ({in_byte, first_r} != msg_id) begin
            err_nxt = ST_MISMATCH; ph_nxt = PH_ERR;
          end else ph_nxt = PH_MODE;
        end
        PH_MODE: begin
          if (in_byte == MARK_COMPACT) begin cmp_nxt = 1'b1; ph_nxt = PH_BSIZE; end
          else begin
            cmp_nxt = 1'b0; cur_nxt = '0;
            if (live == '0) begin err_nxt = ST_BAD; ph_nxt = PH_ERR; end
            else if (c > C_BYT) begin
              res.field_index = cur_r[3:0]; res.field_codec = c; stat.emit = 1'b1;
              err_nxt = ST_BAD; ph_nxt = PH_ERR;
            end else begin
              ph_nxt = PH_FIELD; go = 1'b1;
            end
          end
        end
        PH_BSIZE: begin
          if (in_byte != {3'b0, need}) begin err_nxt = ST_BAD; ph_nxt = PH_ERR; end
          else begin
            seen_nxt = '0; bmap_nxt = '0;
            if (need == '0) begin cur_nxt = '0; start_adv = 1'b1; ph_nxt = PH_DONE; end
            else ph_nxt = PH_BMAP;
          end
        end
        PH_BMAP: begin
          if (seen_r[0]) bmap_nxt[15:8] = in_byte;
          else bmap_nxt[7:0] = in_byte;
          seen_nxt = seen_r + 1'b1;
          if ({11'b0, need} <= seen_r + 1'b1) begin cur_nxt = '0; start_adv = 1'b1; end
        end
        PH_FIELD, PH_DICTID, PH_PAYLOAD: go = 1'b1;
        PH_DONE: begin err_nxt = ST_BAD; ph_nxt = PH_ERR; end
        default: ;
      endcase
      if (go) begin
        unique case (fph)
          PH_FIELD: begin
            if (c <= C_F64) begin
              val_nxt = val_r | (64'(in_byte) << {seen_r[2:0], 3'b000});
              seen_nxt = seen_r + 1'b1;
              if (seen_r + 1'b1 >= {12'b0, fixed_size(c)}) begin
                v = val_nxt;
                case (c)
                  C_I8:  v = {{56{v[7]}}, v[7:0]};
                  C_I16: v = {{48{v[15]}}, v[15:0]};
                  C_I32: v = {{32{v[31]}}, v[31:0]};
                  default: ;
                endcase
                res.field_index = cur_r[3:0]; res.field_codec = c; res.field_value = v;
                stat.emit = 1'b1;
                cur_nxt = cur_r + 1'b1; start_adv = 1'b1;
              end
            end else if (seen_r == '0) begin
              len_nxt = {8'b0, in_byte}; seen_nxt = 16'd1;
            end else begin
              len_nxt = {in_byte, len_r[7:0]}; seen_nxt = '0;
              if (c == C_STR && len_nxt == DICT_LEN) begin
                val_nxt = '0; ph_nxt = PH_DICTID;
              end else if (len_nxt == '0) begin
                res.field_index = cur_r[3:0]; res.field_codec = c;
                res.payload_offset = npos16; stat.emit = 1'b1;
                cur_nxt = cur_r + 1'b1; start_adv = 1'b1;
              end else begin
                val_nxt = 64'(npos); ph_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_DICTID: begin
            if (seen_r == '0) begin val_nxt = 64'(in_byte); seen_nxt = 16'd1; end
            else begin
              res.field_index = cur_r[3:0]; res.field_codec = c;
              res.is_dictionary_ref = 1'b1; res.dictionary_id = {in_byte, val_r[7:0]};
              stat.emit = 1'b1;
              cur_nxt = cur_r + 1'b1; start_adv = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            seen_nxt = seen_r + 1'b1;
            if (seen_nxt >= len_r) begin
              res.field_index = cur_r[3:0]; res.field_codec = c;
              res.payload_offset = val_r[15:0]; res.payload_length = len_r;
              stat.emit = 1'b1;
              cur_nxt = cur_r + 1'b1; start_adv = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (start_adv) begin
        seen_nxt = '0; val_nxt = '0; len_nxt = '0; adv_nxt = 1'b1;
        ph_nxt = PH_FIELD;
      end
    end else if (cmd.adv_go && adv_r) begin
      // One step of the walk: emit a zeroed field, flag a bad codec, or settle on the next phase.
      if (cur_r >= live) begin
        adv_nxt = 1'b0;
        ph_nxt = PH_DONE;
      end else if (c > C_BYT) begin
        res.field_index = cur_r[3:0]; res.field_codec = c; stat.emit = 1'b1;
        adv_nxt = 1'b0; err_nxt = ST_BAD; ph_nxt = PH_ERR;
      end else if (cmp_r && c <= C_F64 && bmap_r[cur_r[3:0]]) begin
        res.field_index = cur_r[3:0]; res.field_codec = c; stat.emit = 1'b1;
        cur_nxt = cur_r + 1'b1;
      end else begin
        adv_nxt = 1'b0; ph_nxt = PH_FIELD;
      end
    end else if (cmd.adv_go && eop_r) begin
      unique case (ph_r)
        PH_ERR: st = err_r;
        PH_B0, PH_B1: st = ST_SMALL;
        PH_MODE: st = (live == '0) ? ST_OK : ST_BAD;
        PH_DONE: st = ST_OK;
        default: st = ST_BAD;
      endcase
      res.result_kind = 1'b1; res.status = st; res.last_result = 1'b1;
      stat.emit = 1'b1;
      pos_nxt = '0; first_nxt = '0; ph_nxt = PH_B0; cmp_nxt = 1'b0; cur_nxt = '0;
      seen_nxt = '0; val_nxt = '0; len_nxt = '0; bmap_nxt = '0; err_nxt = ST_OK;
      eop_nxt = 1'b0;
    end
    stat.adv_pending = adv_nxt;
    stat.busy = eop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; first_r <= '0; ph_r <= PH_B0; cmp_r <= 1'b0; cur_r <= '0;
      seen_r <= '0; val_r <= '0; len_r <= '0; bmap_r <= '0; err_r <= ST_OK;
      adv_r <= 1'b0; eop_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; first_r <= first_nxt; cmp_r <= cmp_nxt; cur_r <= cur_nxt;
      seen_r <= seen_nxt; val_r <= val_nxt; len_r <= len_nxt; bmap_r <= bmap_nxt;
      adv_r <= adv_nxt; eop_r <= eop_nxt;
      ph_r <= ph_nxt; err_r <= err_nxt;
    end
  end
endmodule
`default_nettype wire

// File: sv/schema_packet_field_decoder.sv
// Schema packet field decoder: one packet byte per item, at most one result per cycle.
// A result that a byte completes is registered and valid on the next cycle. A byte
// that completes a field or the compact header starts a walk that emits a result per
// zeroed field, then settles; the flagged last byte adds a status result. A byte that
// completes nothing sustains one item per cycle unless the output stalls. Synchronous
// active-low reset clears config registers to zero, packet state to the header phase.
`default_nettype none
module schema_packet_field_decoder import spfd_pkg::*; #(
  parameter int FIELD_SLOTS = 16,
  parameter int OFFSET_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spfd_in_if.sink   in_ch,
  spfd_out_if.source out_ch,
  spfd_cfg_if.sink  cfg_ch
);
  logic [15:0] msg_id_r;
  logic [4:0]  fcount_r;
  logic [63:0] codecs_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;
  logic     out_v_r;
  result_t  out_r;
  logic     out_free;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_id_r <= '0; fcount_r <= '0; codecs_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MSG_ID: msg_id_r <= cfg_ch.data[15:0];
        REG_COUNT:  fcount_r <= cfg_ch.data[4:0];
        REG_CODECS: codecs_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_v_r || out_ch.ready;

  spfd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_eop(in_ch.end_of_packet), .out_free(out_free), .stat(stat), .cmd(cmd)
  );

  spfd_dp #(.FIELD_SLOTS(FIELD_SLOTS), .OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_byte(in_ch.in_byte), .cmd(cmd),
    .msg_id(msg_id_r), .fcount(fcount_r), .codecs(codecs_r), .stat(stat), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_free) out_v_r <= stat.emit;
  end
  always_ff @(posedge clk) begin
    if (out_free && stat.emit) out_r <= res;
  end
  assign out_ch.valid = out_v_r;
  assign out_ch.res = out_r;
endmodule
`default_nettype wire
